@@ design/tbds_pkg.sv @@
// Shared types, widths and codes for the timer bank deadline scanner.
`default_nettype none
package tbds_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int CNT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam int FUNC_W   = 3;
    localparam int TID_W    = 4;
    localparam int PERIOD_W = 31;
    localparam int TIME_W   = 63;
    localparam int CLK_W    = 14;
    localparam int MS_W     = 10;
    localparam int PROD1_W  = PERIOD_W + CLK_W;
    localparam int PROD2_W  = PROD1_W + MS_W;
    localparam int SUM_W    = TIME_W + 1;

    localparam logic [TIME_W-1:0] MAX63          = {TIME_W{1'b1}};
    localparam logic [CLK_W-1:0]  RATE_MHZ_RESET = CLK_W'(1000);
    localparam logic [MS_W-1:0]   MS_PER_SEC_K   = MS_W'(1000);

    // Timer modes
    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_EXPIRED = 2'd2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_START   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FORCE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ADJUST  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SCAN    = 3'd6;

    typedef struct packed {
        logic [1:0]          mode;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   deadline;
        logic                fired;
    } timer_rec_t;

    typedef struct packed {
        logic                go;
        logic [PERIOD_W-1:0] period_ms;
        logic [TIME_W-1:0]   now;
    } arm_req_t;

endpackage
`default_nettype wire

@@ design/timer_bank_deadline_scan.sv @@
// Top level of the timer bank: command sequencer, rotating timer ring and result register.
`default_nettype none
// Bank of NUM_TIMERS deadline timers driven by one command item at a time. A command
// (start, restart, stop, force stop, adjust, query) returns one item with the addressed
// timer's state. A command that does not arm steps through the command and response
// states and loads its result into the output register; an arming command also waits
// in the arm state for the deadline multiply pipeline. A scan rotates the ring of
// timer cells twice past the head cell: the first lap expires overdue timers and
// rebuilds the earliest deadline, the second lap emits one event item per timer that
// the first lap expired, then a summary item closes the scan; an event item or the
// summary waits while the result side stalls. The next item is accepted once the
// current one is finished, even while its last result still waits in the output
// register. The clock-rate register may only be written while the block is idle.
module timer_bank_deadline_scan
    import tbds_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration: clock rate in MHz
    input  wire logic               cfg_wr_en,
    input  wire logic [CLK_W-1:0]   cfg_wr_data,
    // command items
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [103:0]       s_tdata,   // func[2:0], timer_index[6:3],
                                               // period_ms[37:7], now[100:38]
    // result items
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [103:0]            m_tdata,   // timer_id[3:0], expired flag[4],
                                               // period_out[35:5],
                                               // earliest_deadline[98:36]
    output logic                    m_tuser,   // expire_event
    output logic                    m_tlast    // last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMD   = 3'd1;
    localparam logic [2:0] ST_ARM   = 3'd2;
    localparam logic [2:0] ST_RESP  = 3'd3;
    localparam logic [2:0] ST_SCAN1 = 3'd4;
    localparam logic [2:0] ST_SCAN2 = 3'd5;
    localparam logic [2:0] ST_SUMM  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CLK_W-1:0]    rate_mhz_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [TID_W-1:0]    idx_reg;
    logic [PERIOD_W-1:0] pms_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   min_reg, min_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // output register
    logic                m_valid_reg;
    logic [TID_W-1:0]    o_id_reg;
    logic                o_ev_reg, o_ex_reg, o_last_reg;
    logic [PERIOD_W-1:0] o_per_reg;
    logic [TIME_W-1:0]   o_dl_reg;
    logic                out_free, out_load;
    logic [TID_W-1:0]    o_id_next;
    logic                o_ev_next, o_ex_next, o_last_next;
    logic [PERIOD_W-1:0] o_per_next;

    // ring
    timer_rec_t          cell_rec [NUM_TIMERS];
    timer_rec_t          head_proc, wr_rec, cur;
    logic [NUM_TIMERS-1:0] wr_en;
    logic                shift_en;
    logic                idx_ok;
    logic [CNT_W-1:0]    idx_sel;
    logic                cnt_last;

    arm_req_t            arm_req;
    logic                arm_done;
    logic [TIME_W-1:0]   arm_deadline;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign idx_ok   = (32'(idx_reg) < NUM_TIMERS);
    assign idx_sel  = CNT_W'(idx_reg);
    assign cur      = cell_rec[idx_sel];
    assign cnt_last = (cnt_reg == CNT_W'(NUM_TIMERS - 1));

    tbds_arm u_arm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (arm_req),
        .rate_mhz  (rate_mhz_reg),
        .done      (arm_done),
        .deadline  (arm_deadline)
    );

    // cell i takes cell i+1; the processed head record re-enters at the tail
    for (genvar gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
        timer_rec_t nb;
        if (gi == NUM_TIMERS - 1) begin : g_tail
            assign nb = head_proc;
        end else begin : g_mid
            assign nb = cell_rec[gi + 1];
        end
        tbds_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .shift_in (nb),
            .wr_en    (wr_en[gi]),
            .wr_rec   (wr_rec),
            .rec      (cell_rec[gi])
        );
    end

    always_comb begin
        state_next  = state_reg;
        min_next    = min_reg;
        cnt_next    = cnt_reg;
        head_proc   = cell_rec[0];
        shift_en    = 1'b0;
        wr_en       = '0;
        wr_rec      = cur;
        arm_req.go        = 1'b0;
        arm_req.period_ms = cur.period;
        arm_req.now       = now_reg;
        out_load    = 1'b0;
        o_id_next   = idx_reg;
        o_ev_next   = 1'b0;
        o_ex_next   = 1'b0;
        o_per_next  = '0;
        o_last_next = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[2:0] == FUNC_SCAN) begin
                        state_next = ST_SCAN1;
                        min_next   = MAX63;
                        cnt_next   = '0;
                    end else begin
                        state_next = ST_CMD;
                    end
                end
            end
            ST_CMD: begin
                state_next = ST_RESP;
                if (idx_ok) begin
                    case (func_reg)
                        FUNC_START: begin
                            if (cur.mode == MODE_STOPPED) begin
                                arm_req.go = 1'b1;
                                state_next = ST_ARM;
                            end
                        end
                        FUNC_RESTART: begin
                            arm_req.go = 1'b1;
                            state_next = ST_ARM;
                        end
                        FUNC_STOP: begin
                            if (cur.mode == MODE_RUNNING) begin
                                wr_rec.mode      = MODE_STOPPED;
                                wr_en[idx_sel]   = 1'b1;
                            end
                        end
                        FUNC_FORCE: begin
                            wr_rec.mode    = MODE_STOPPED;
                            wr_en[idx_sel] = 1'b1;
                        end
                        FUNC_ADJUST: begin
                            wr_rec.period  = pms_reg;
                            wr_en[idx_sel] = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ARM: begin
                if (arm_done) begin
                    wr_rec.mode     = MODE_RUNNING;
                    wr_rec.deadline = arm_deadline;
                    wr_en[idx_sel]  = 1'b1;
                    if (arm_deadline < min_reg) begin
                        min_next = arm_deadline;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    o_ex_next  = idx_ok && (cur.mode == MODE_EXPIRED);
                    o_per_next = idx_ok ? cur.period : '0;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN1: begin
                // first lap: expire overdue timers, fold the rest into the minimum
                shift_en = 1'b1;
                if (cell_rec[0].mode == MODE_RUNNING) begin
                    if (cell_rec[0].deadline < now_reg) begin
                        head_proc.mode  = MODE_EXPIRED;
                        head_proc.fired = 1'b1;
                    end else if (cell_rec[0].deadline < min_reg) begin
                        min_next = cell_rec[0].deadline;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    cnt_next   = '0;
                    state_next = ST_SCAN2;
                end
            end
            ST_SCAN2: begin
                // second lap: report each fired timer, minimum is now final
                o_id_next   = TID_W'(cnt_reg);
                o_ev_next   = 1'b1;
                o_ex_next   = 1'b1;
                o_per_next  = cell_rec[0].period;
                o_last_next = 1'b0;
                head_proc.fired = 1'b0;
                if (!cell_rec[0].fired || out_free) begin
                    shift_en = 1'b1;
                    out_load = cell_rec[0].fired;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_last) begin
                        state_next = ST_SUMM;
                    end
                end
            end
            ST_SUMM: begin
                o_id_next = '0;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rate_mhz_reg <= RATE_MHZ_RESET;
            min_reg      <= MAX63;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            min_reg   <= min_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                rate_mhz_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg <= s_tdata[2:0];
            idx_reg  <= s_tdata[6:3];
            pms_reg  <= s_tdata[37:7];
            now_reg  <= s_tdata[100:38];
        end
        if (out_load) begin
            o_id_reg   <= o_id_next;
            o_ev_reg   <= o_ev_next;
            o_ex_reg   <= o_ex_next;
            o_per_reg  <= o_per_next;
            o_dl_reg   <= min_reg;
            o_last_reg <= o_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, o_dl_reg, o_per_reg, o_ex_reg, o_id_reg};
    assign m_tuser  = o_ev_reg;
    assign m_tlast  = o_last_reg;

endmodule
`default_nettype wire

@@ design/tbds_cell.sv @@
// One timer slot of the rotating ring: loads a command write or its neighbor's record.
`default_nettype none
module tbds_cell
    import tbds_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       shift_en,
    input  wire timer_rec_t shift_in,
    input  wire logic       wr_en,
    input  wire timer_rec_t wr_rec,
    output timer_rec_t      rec
);

    logic [1:0]          mode_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic                fired_reg;

    // mode, period and fired flag have defined reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_STOPPED;
            period_reg <= '0;
            fired_reg  <= 1'b0;
        end else if (wr_en) begin
            mode_reg   <= wr_rec.mode;
            period_reg <= wr_rec.period;
            fired_reg  <= wr_rec.fired;
        end else if (shift_en) begin
            mode_reg   <= shift_in.mode;
            period_reg <= shift_in.period;
            fired_reg  <= shift_in.fired;
        end
    end

    // deadline is only read while running, so no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            deadline_reg <= wr_rec.deadline;
        end else if (shift_en) begin
            deadline_reg <= shift_in.deadline;
        end
    end

    assign rec = '{mode: mode_reg, period: period_reg, deadline: deadline_reg,
                   fired: fired_reg};

endmodule
`default_nettype wire

@@ design/tbds_arm.sv @@
// Deadline pipeline: now + period_ms * rate_mhz * 1000, saturated.
`default_nettype none
module tbds_arm
    import tbds_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire arm_req_t          req,
    input  wire logic [CLK_W-1:0]  rate_mhz,
    output logic                   done,
    output logic [TIME_W-1:0]      deadline
);

    logic                v1_reg, v2_reg, v3_reg;
    logic [PROD1_W-1:0]  p1_reg, p1_next;
    logic [PROD2_W-1:0]  p2_reg, p2_next;
    logic [TIME_W-1:0]   now1_reg, now2_reg;
    logic [TIME_W-1:0]   dl_reg, dl_next;
    logic [SUM_W-1:0]    sum;

    assign p1_next = PROD1_W'(req.period_ms) * PROD1_W'(rate_mhz);
    assign p2_next = PROD2_W'(p1_reg) * PROD2_W'(MS_PER_SEC_K);
    assign sum     = SUM_W'(now2_reg) + SUM_W'(p2_reg);
    assign dl_next = sum[SUM_W-1] ? MAX63 : sum[TIME_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= req.go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg   <= p1_next;
        now1_reg <= req.now;
        p2_reg   <= p2_next;
        now2_reg <= now1_reg;
        dl_reg   <= dl_next;
    end

    assign done     = v3_reg;
    assign deadline = dl_reg;

endmodule
`default_nettype wire
